// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SLPO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLPO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/slpo_pkg.sv -----
// ----------------------------------------------------------------------------
// slpo_pkg
// Item types, register indexes and table builders for the lateral path offset
// ----------------------------------------------------------------------------
package slpo_pkg;

   typedef struct packed {
      logic [15:0]        point_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        heading;
      logic signed [31:0] path_curvature;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_index;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [15:0]        out_heading;
      logic signed [23:0] applied_offset;
   } rsp_type;

   localparam logic [1:0] CSR_ROLL_IN     = 2'd0;
   localparam logic [1:0] CSR_MAX_OFFSET  = 2'd1;
   localparam logic [1:0] CSR_BIAS_OFFSET = 2'd2;

   localparam longint unsigned ONE_Q30 = 64'h0000_0000_4000_0000;
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam int TRIG_DEPTH = 16384;

   // bit-serial divide, used only when tables are built
   function automatic longint unsigned udiv64(input longint unsigned n,
                                              input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // sigmoid of the bin centre in Q16
   function automatic logic [16:0] sig_entry(input int unsigned idx,
                                             input int unsigned tbits);
      longint unsigned cu;
      longint signed   centre;
      longint unsigned t;
      longint unsigned term;
      longint signed   sum;
      longint unsigned e;
      longint unsigned den;
      longint unsigned num;
      longint unsigned q;
      cu = longint'(2 * idx + 1) << (33 - tbits);
      centre = $signed(cu) - $signed(ONE_Q30 << 3);
      t = $unsigned(centre < 0 ? -centre : centre) >> 4;
      term = ONE_Q30;
      sum = $signed(ONE_Q30);
      term = ((term * t) >> 30);       sum = sum - $signed(term);
      term = ((term * t) >> 30) / 2;   sum = sum + $signed(term);
      term = ((term * t) >> 30) / 3;   sum = sum - $signed(term);
      term = ((term * t) >> 30) / 4;   sum = sum + $signed(term);
      term = ((term * t) >> 30) / 5;   sum = sum - $signed(term);
      term = ((term * t) >> 30) / 6;   sum = sum + $signed(term);
      term = ((term * t) >> 30) / 7;   sum = sum - $signed(term);
      term = ((term * t) >> 30) / 8;   sum = sum + $signed(term);
      term = ((term * t) >> 30) / 9;   sum = sum - $signed(term);
      term = ((term * t) >> 30) / 10;  sum = sum + $signed(term);
      e = $unsigned(sum);
      for (int k = 0; k < 4; k++) begin
         e = (e * e) >> 30;
      end
      den = ONE_Q30 + e;
      if (centre >= 0) begin
         num = (64'd1 << 46) + (den >> 1);
      end else begin
         num = (e << 16) + (den >> 1);
      end
      q = udiv64(num, den);
      return q[16:0];
   endfunction

   // first-quadrant {sin, cos} in Q30 for a 14-bit angle remainder
   function automatic logic [63:0] trig_entry(input int unsigned r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned ts;
      longint unsigned tc;
      longint signed   sn;
      longint signed   cs;
      x = (longint'(r) * PI_Q30) >> 15;
      x2 = (x * x) >> 30;
      ts = x;
      tc = ONE_Q30;
      sn = $signed(x);
      cs = $signed(ONE_Q30);
      ts = ((ts * x2) >> 30) / 6;    tc = ((tc * x2) >> 30) / 2;
      sn = sn - $signed(ts);         cs = cs - $signed(tc);
      ts = ((ts * x2) >> 30) / 20;   tc = ((tc * x2) >> 30) / 12;
      sn = sn + $signed(ts);         cs = cs + $signed(tc);
      ts = ((ts * x2) >> 30) / 42;   tc = ((tc * x2) >> 30) / 30;
      sn = sn - $signed(ts);         cs = cs - $signed(tc);
      ts = ((ts * x2) >> 30) / 72;   tc = ((tc * x2) >> 30) / 56;
      sn = sn + $signed(ts);         cs = cs + $signed(tc);
      ts = ((ts * x2) >> 30) / 110;  tc = ((tc * x2) >> 30) / 90;
      sn = sn - $signed(ts);         cs = cs - $signed(tc);
      ts = ((ts * x2) >> 30) / 156;  tc = ((tc * x2) >> 30) / 132;
      sn = sn + $signed(ts);         cs = cs + $signed(tc);
      return {sn[31:0], cs[31:0]};
   endfunction

endpackage

// ----- rtl/sigmoid_lateral_path_offset.sv -----
// an item passes the divider stages, then the table read, scale, offset, filter and output stages
// throughput: one item per cycle unless the output stalls; the quotient for the sigmoid bin is formed
// one bit per pipeline stage, so depth grows with the table size
// a waypoint that fails the curvature test leaves a bubble and gives no result
// reset: synchronous; empties the pipeline and loads roll-in 10, offsets 0
// ----------------------------------------------------------------------------
// sigmoid_lateral_path_offset
// Pipelined sigmoid lateral shift of path waypoints with curvature filtering
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sigmoid_lateral_path_offset #(
   parameter int INDEX_BITS         = 16,
   parameter int SIGMOID_TABLE_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slpo_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slpo_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [22:0]       csr_data
);
   import slpo_pkg::*;

   localparam int IDX_W     = (INDEX_BITS < 16) ? INDEX_BITS : 16;
   localparam int TB        = SIGMOID_TABLE_BITS;
   localparam int SIG_DEPTH = 1 << TB;
   localparam int SUM_W     = (((IDX_W + 3) > 19) ? (IDX_W + 3) : 19) + 1;
   localparam int NUM_W     = SUM_W + TB - 2;
   localparam int DEN_W     = 19;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      req_type          pay;
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [TB-1:0]    quo;
      logic             sat;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -34'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // configuration
   logic [15:0]        roll_len_ff;
   logic signed [22:0] max_off_ff;
   logic signed [22:0] bias_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_len_ff <= 16'd10;
         max_off_ff  <= '0;
         bias_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROLL_IN:     roll_len_ff <= (csr_data[15:0] == 16'd0) ? 16'd1 : csr_data[15:0];
            CSR_MAX_OFFSET:  max_off_ff  <= $signed(csr_data);
            CSR_BIAS_OFFSET: bias_ff     <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the output holds a stalled item
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // constant tables
   logic [16:0] sig_rom  [SIG_DEPTH];
   logic [63:0] trig_rom [TRIG_DEPTH];

   for (genvar g = 0; g < SIG_DEPTH; g++) begin : g_sig
      assign sig_rom[g] = sig_entry(g, TB);
   end
   for (genvar g = 0; g < TRIG_DEPTH; g++) begin : g_trig
      assign trig_rom[g] = trig_entry(g);
   end

   // divider pipeline: bin = (8j + 7L) * 2^(TB-2) / 5L, saturated when 8j >= 13L
   div_type     div_in [TB+1];
   div_type     div_ff [TB+1];
   logic [TB:0] div_v_ff;

   logic [IDX_W-1:0] j_w;
   logic [SUM_W-1:0] sum_w;
   logic [19:0]      j8_w;
   logic [19:0]      l13_w;

   always_comb begin
      logic [NUM_W-1:0] trial;
      j_w   = req_payload.point_index[IDX_W-1:0];
      sum_w = SUM_W'({j_w, 3'b000}) + SUM_W'({roll_len_ff, 3'b000}) - SUM_W'(roll_len_ff);
      j8_w  = 20'({j_w, 3'b000});
      l13_w = 20'({roll_len_ff, 3'b000}) + 20'({roll_len_ff, 2'b00}) + 20'(roll_len_ff);
      div_in[0].pay = req_payload;
      div_in[0].rem = {sum_w, {(TB - 2){1'b0}}};
      div_in[0].den = DEN_W'({roll_len_ff, 2'b00}) + DEN_W'(roll_len_ff);
      div_in[0].quo = '0;
      div_in[0].sat = (j8_w >= l13_w);
      for (int k = 1; k <= TB; k++) begin
         div_in[k] = div_ff[k-1];
         trial = NUM_W'(div_ff[k-1].den) << (TB - k);
         if (div_ff[k-1].rem >= trial) begin
            div_in[k].rem = div_ff[k-1].rem - trial;
            div_in[k].quo = {div_ff[k-1].quo[TB-2:0], 1'b1};
         end else begin
            div_in[k].quo = {div_ff[k-1].quo[TB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff <= '0;
      end else if (adv) begin
         div_v_ff <= {div_v_ff[TB-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= TB; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // table read stage
   logic [TB-1:0] sig_idx_in;
   logic [16:0]   rom_sig_ff;
   logic [63:0]   rom_trig_ff;
   req_type       rom_pay_ff;
   logic          rom_v_ff;

   assign sig_idx_in = div_ff[TB].sat ? {TB{1'b1}} : div_ff[TB].quo;

   always_ff @(posedge clock) begin
      if (adv) begin
         rom_sig_ff  <= sig_rom[sig_idx_in];
         rom_trig_ff <= trig_rom[div_ff[TB].pay.heading[13:0]];
         rom_pay_ff  <= div_ff[TB].pay;
      end
   end

   // scale stage: sigmoid product and quadrant mapping
   logic signed [40:0] prod_in;
   logic signed [31:0] sn_w;
   logic signed [31:0] cs_w;
   logic signed [32:0] s_in;
   logic signed [32:0] c_in;
   logic signed [40:0] mul_prod_ff;
   logic signed [32:0] mul_s_ff;
   logic signed [32:0] mul_c_ff;
   req_type            mul_pay_ff;
   logic               mul_v_ff;

   assign prod_in = 41'(max_off_ff) * $signed(41'({1'b0, rom_sig_ff}));
   assign sn_w    = $signed(rom_trig_ff[63:32]);
   assign cs_w    = $signed(rom_trig_ff[31:0]);

   always_comb begin
      unique case (rom_pay_ff.heading[15:14])
         QUAD_0: begin
            s_in = 33'(sn_w);
            c_in = 33'(cs_w);
         end
         QUAD_1: begin
            s_in = 33'(cs_w);
            c_in = -33'(sn_w);
         end
         QUAD_2: begin
            s_in = -33'(sn_w);
            c_in = -33'(cs_w);
         end
         QUAD_3: begin
            s_in = -33'(cs_w);
            c_in = 33'(sn_w);
         end
         default: begin
            s_in = 33'(sn_w);
            c_in = 33'(cs_w);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_prod_ff <= prod_in;
         mul_s_ff    <= s_in;
         mul_c_ff    <= c_in;
         mul_pay_ff  <= rom_pay_ff;
      end
   end

   // offset stage
   logic signed [40:0] rnd_w;
   logic signed [23:0] off_in;
   logic signed [23:0] off_ff;
   logic signed [32:0] off_s_ff;
   logic signed [32:0] off_c_ff;
   req_type            off_pay_ff;
   logic               off_v_ff;

   assign rnd_w  = mul_prod_ff + 41'sd32768;
   assign off_in = $signed(rnd_w[39:16]) + 24'(bias_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff     <= off_in;
         off_s_ff   <= mul_s_ff;
         off_c_ff   <= mul_c_ff;
         off_pay_ff <= mul_pay_ff;
      end
   end

   // filter and shift products
   logic [31:0]        acurv_w;
   logic [23:0]        aoff_w;
   logic [56:0]        kprod_in;
   logic               sgn_keep_in;
   logic signed [33:0] neg_s_w;
   logic signed [57:0] dxp_in;
   logic signed [57:0] dyp_in;
   logic [56:0]        kp_prod_ff;
   logic               kp_sgn_ff;
   logic signed [57:0] kp_dxp_ff;
   logic signed [57:0] kp_dyp_ff;
   logic signed [23:0] kp_off_ff;
   req_type            kp_pay_ff;
   logic               kp_v_ff;

   assign acurv_w = off_pay_ff.path_curvature[31] ? (~off_pay_ff.path_curvature + 32'd1)
                                                  : off_pay_ff.path_curvature;
   assign aoff_w  = off_ff[23] ? (~off_ff + 24'd1) : off_ff;
   assign kprod_in = 57'(acurv_w) * 57'(25'(aoff_w) + 25'd65536);
   assign sgn_keep_in = (off_pay_ff.path_curvature < 0 && off_ff > 0) ||
                        (off_pay_ff.path_curvature > 0 && off_ff < 0);
   assign neg_s_w = -34'(off_s_ff);
   assign dxp_in  = 58'(off_ff) * 58'(neg_s_w);
   assign dyp_in  = 58'(off_ff) * 58'(off_c_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         kp_prod_ff <= kprod_in;
         kp_sgn_ff  <= sgn_keep_in;
         kp_dxp_ff  <= dxp_in;
         kp_dyp_ff  <= dyp_in;
         kp_off_ff  <= off_ff;
         kp_pay_ff  <= off_pay_ff;
      end
   end

   // output stage
   logic               keep_w;
   logic signed [57:0] dxr_w;
   logic signed [57:0] dyr_w;
   logic signed [33:0] x_w;
   logic signed [33:0] y_w;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_pay_ff;

   assign keep_w = kp_sgn_ff || (kp_prod_ff < (57'd1 << 40));
   assign dxr_w  = kp_dxp_ff + 58'sd536870912;
   assign dyr_w  = kp_dyp_ff + 58'sd536870912;
   assign x_w    = 34'(kp_pay_ff.pos_x) + 34'($signed(dxr_w[57:30]));
   assign y_w    = 34'(kp_pay_ff.pos_y) + 34'($signed(dyr_w[57:30]));

   always_comb begin
      rsp_in.out_index      = kp_pay_ff.point_index;
      rsp_in.out_x          = sat32(x_w);
      rsp_in.out_y          = sat32(y_w);
      rsp_in.out_heading    = kp_pay_ff.heading;
      rsp_in.applied_offset = kp_off_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pay_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_v_ff     <= 1'b0;
         mul_v_ff     <= 1'b0;
         off_v_ff     <= 1'b0;
         kp_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rom_v_ff     <= div_v_ff[TB];
         mul_v_ff     <= rom_v_ff;
         off_v_ff     <= mul_v_ff;
         kp_v_ff      <= off_v_ff;
         rsp_valid_ff <= kp_v_ff && keep_w;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_pay_ff;

   // a kept item reaches the output, a dropped one leaves a bubble
   `SLPO_ASSERT_NEXT(a_keep_to_output, clock, reset, (kp_v_ff && adv), (rsp_valid == $past(keep_w)), "kept item lost or dropped item shown")
   // sigmoid table never exceeds one in Q16
   `SLPO_ASSERT_IMPL(a_sig_range, clock, reset, rom_v_ff, (rom_sig_ff <= 17'd65536), "sigmoid value out of range")

endmodule
